// ===== sv/gtr_pkg.sv =====
`timescale 1ns / 1ps

package gtr_pkg;

    localparam int unsigned CFG_W = 13;
    localparam logic [CFG_W-1:0] PANEL_MAX = 13'd4096;
    localparam logic [CFG_W-1:0] PANEL_W_RESET = 13'd128;
    localparam logic [CFG_W-1:0] PANEL_H_RESET = 13'd160;

    localparam logic [7:0] GLYPH_FIRST = 8'd32;
    localparam logic [7:0] GLYPH_LAST = 8'd90;
    localparam logic [15:0] CHAR_ADVANCE = 16'd6;
    localparam logic [2:0] LAST_COL = 3'd4;
    localparam logic [2:0] LAST_ROW = 3'd6;

    typedef enum logic [0:0] {
        REG_PANEL_WIDTH = 1'b0,
        REG_PANEL_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic        cmd;
        logic [15:0] start_x;
        logic [15:0] start_y;
        logic [7:0]  character;
        logic [15:0] fore_color;
        logic [15:0] back_color;
    } t_in_word;

    typedef struct packed {
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic [15:0] pixel_color;
        logic        last_pixel;
    } t_out_word;

    typedef struct packed {
        logic latch;
        logic load;
        logic step;
        logic advance;
    } t_ctl_cmd;

    typedef struct packed {
        logic drawable;
        logic at_end;
        logic out_free;
    } t_dp_status;

    // Glyph columns 0..4 from the most significant byte down.
    function automatic logic [39:0] glyph_bits(input logic [5:0] idx);
        logic [39:0] g;
        case (idx)
            6'd0:  g = 40'h0000000000;
            6'd1:  g = 40'h00005F0000;
            6'd2:  g = 40'h0007000700;
            6'd3:  g = 40'h147F147F14;
            6'd4:  g = 40'h242A7F2A12;
            6'd5:  g = 40'h2313086462;
            6'd6:  g = 40'h3649552250;
            6'd7:  g = 40'h0005030000;
            6'd8:  g = 40'h001C224100;
            6'd9:  g = 40'h0041221C00;
            6'd10: g = 40'h14083E0814;
            6'd11: g = 40'h08083E0808;
            6'd12: g = 40'h0050300000;
            6'd13: g = 40'h0808080808;
            6'd14: g = 40'h0060600000;
            6'd15: g = 40'h2010080402;
            6'd16: g = 40'h3E5149453E;
            6'd17: g = 40'h00427F4000;
            6'd18: g = 40'h4261514946;
            6'd19: g = 40'h2141454B31;
            6'd20: g = 40'h1814127F10;
            6'd21: g = 40'h2745454539;
            6'd22: g = 40'h3C4A494930;
            6'd23: g = 40'h0171090503;
            6'd24: g = 40'h3649494936;
            6'd25: g = 40'h064949291E;
            6'd26: g = 40'h0036360000;
            6'd27: g = 40'h0056360000;
            6'd28: g = 40'h0814224100;
            6'd29: g = 40'h1414141414;
            6'd30: g = 40'h0041221408;
            6'd31: g = 40'h0201510906;
            6'd32: g = 40'h324979413E;
            6'd33: g = 40'h7E1111117E;
            6'd34: g = 40'h7F49494936;
            6'd35: g = 40'h3E41414122;
            6'd36: g = 40'h7F4141221C;
            6'd37: g = 40'h7F49494941;
            6'd38: g = 40'h7F09090901;
            6'd39: g = 40'h3E4149497A;
            6'd40: g = 40'h7F0808087F;
            6'd41: g = 40'h00417F4100;
            6'd42: g = 40'h2040413F01;
            6'd43: g = 40'h7F08142241;
            6'd44: g = 40'h7F40404040;
            6'd45: g = 40'h7F020C027F;
            6'd46: g = 40'h7F0408107F;
            6'd47: g = 40'h3E4141413E;
            6'd48: g = 40'h7F09090906;
            6'd49: g = 40'h3E4151215E;
            6'd50: g = 40'h7F09192946;
            6'd51: g = 40'h4649494931;
            6'd52: g = 40'h01017F0101;
            6'd53: g = 40'h3F4040403F;
            6'd54: g = 40'h1F2040201F;
            6'd55: g = 40'h3F4038403F;
            6'd56: g = 40'h6314081463;
            6'd57: g = 40'h0708700807;
            6'd58: g = 40'h6151494543;
            default: g = 40'h0000000000;
        endcase
        return g;
    endfunction

endpackage

// ===== sv/gtr_ctrl.sv =====
`timescale 1ns / 1ps

module gtr_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  gtr_pkg::t_dp_status i_status,
    output logic                o_in_ready,
    output gtr_pkg::t_ctl_cmd   o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_in_ready = 1'b0;
        o_cmd = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (i_status.drawable) begin
                    o_cmd.load = 1'b1;
                    n_state = ST_RUN;
                end else begin
                    // nothing to draw: still move the cursor
                    o_cmd.advance = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_RUN: begin
                if (i_status.out_free) begin
                    o_cmd.step = 1'b1;
                    if (i_status.at_end) begin
                        o_cmd.advance = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== sv/gtr_datapath.sv =====
`timescale 1ns / 1ps

module gtr_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_index,
    input  logic [12:0]           i_cfg_data,
    input  gtr_pkg::t_in_word     i_in_word,
    input  gtr_pkg::t_ctl_cmd     i_cmd,
    input  logic                  i_out_ready,
    output gtr_pkg::t_dp_status   o_status,
    output logic                  o_out_valid,
    output gtr_pkg::t_out_word    o_out_word
);

    logic [12:0] r_panel_w;
    logic [12:0] r_panel_h;
    logic [15:0] r_cur_col;
    logic [15:0] r_cur_row;
    logic [7:0]  r_char;
    logic [15:0] r_fg;
    logic [15:0] r_bg;
    logic [39:0] r_glyph;
    logic [4:0]  r_col_ok;
    logic [6:0]  r_row_ok;
    logic [2:0]  r_col;
    logic [2:0]  r_row;
    logic        r_out_valid;
    gtr_pkg::t_out_word r_out_word;

    logic [12:0] w_eff;
    logic [12:0] h_eff;
    logic [4:0]  col_ok;
    logic [6:0]  row_ok;
    logic [5:0]  glyph_idx;
    logic [7:0]  col_byte;
    logic [2:0]  last_c;
    logic [2:0]  last_r;
    logic        hit;
    logic        emit;
    logic [15:0] pix_x;
    logic [15:0] pix_y;

    assign w_eff = (r_panel_w > gtr_pkg::PANEL_MAX) ? gtr_pkg::PANEL_MAX : r_panel_w;
    assign h_eff = (r_panel_h > gtr_pkg::PANEL_MAX) ? gtr_pkg::PANEL_MAX : r_panel_h;
    assign glyph_idx = 6'(r_char - gtr_pkg::GLYPH_FIRST);

    always_comb begin
        for (int c = 0; c < 5; c++) begin
            col_ok[c] = (16'(r_cur_col + 16'(c))) < {3'b000, w_eff};
        end
        for (int r = 0; r < 7; r++) begin
            row_ok[r] = (16'(r_cur_row + 16'(r))) < {3'b000, h_eff};
        end
    end

    // highest visible column and row mark the final pixel
    always_comb begin
        last_c = 3'd0;
        last_r = 3'd0;
        for (int c = 0; c < 5; c++) begin
            if (r_col_ok[c]) begin
                last_c = 3'(c);
            end
        end
        for (int r = 0; r < 7; r++) begin
            if (r_row_ok[r]) begin
                last_r = 3'(r);
            end
        end
    end

    always_comb begin
        case (r_col)
            3'd0: col_byte = r_glyph[39:32];
            3'd1: col_byte = r_glyph[31:24];
            3'd2: col_byte = r_glyph[23:16];
            3'd3: col_byte = r_glyph[15:8];
            3'd4: col_byte = r_glyph[7:0];
            default: col_byte = 8'h00;
        endcase
    end

    assign hit = r_col_ok[r_col] && r_row_ok[r_row];
    assign emit = i_cmd.step && hit;
    assign pix_x = r_cur_col + {13'd0, r_col};
    assign pix_y = r_cur_row + {13'd0, r_row};

    assign o_status.drawable = (r_char >= gtr_pkg::GLYPH_FIRST) &&
                               (r_char <= gtr_pkg::GLYPH_LAST);
    assign o_status.at_end = (r_col == gtr_pkg::LAST_COL) && (r_row == gtr_pkg::LAST_ROW);
    assign o_status.out_free = !r_out_valid || i_out_ready;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_panel_w <= gtr_pkg::PANEL_W_RESET;
            r_panel_h <= gtr_pkg::PANEL_H_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gtr_pkg::REG_PANEL_WIDTH:  r_panel_w <= i_cfg_data;
                gtr_pkg::REG_PANEL_HEIGHT: r_panel_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // cursor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_col <= '0;
            r_cur_row <= '0;
        end else if (i_cmd.latch && !i_in_word.cmd) begin
            r_cur_col <= i_in_word.start_x;
            r_cur_row <= i_in_word.start_y;
        end else if (i_cmd.advance) begin
            r_cur_col <= r_cur_col + gtr_pkg::CHAR_ADVANCE;
        end
    end

    // item payload, glyph and visibility masks
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_char <= i_in_word.character;
            r_fg <= i_in_word.fore_color;
            r_bg <= i_in_word.back_color;
        end
        if (i_cmd.load) begin
            r_glyph <= gtr_pkg::glyph_bits(glyph_idx);
            r_col_ok <= col_ok;
            r_row_ok <= row_ok;
        end
    end

    // column-major scan position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.load) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.step) begin
            if (r_row == gtr_pkg::LAST_ROW) begin
                r_row <= '0;
                r_col <= r_col + 3'd1;
            end else begin
                r_row <= r_row + 3'd1;
            end
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_word.pixel_x <= pix_x[11:0];
            r_out_word.pixel_y <= pix_y[11:0];
            r_out_word.pixel_color <= col_byte[r_row] ? r_fg : r_bg;
            r_out_word.last_pixel <= (r_col == last_c) && (r_row == last_r);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word = r_out_word;

endmodule

// ===== sv/glyph_5x7_text_rasterizer_core.sv =====
`timescale 1ns / 1ps
// Channel  | Handshake                 | Word
// ---------+---------------------------+----------------------------------------
// input    | i_in_valid / o_in_ready   | i_in_word  (gtr_pkg::t_in_word)
// output   | o_out_valid / i_out_ready | o_out_word (gtr_pkg::t_out_word)
// config   | i_cfg_we                  | i_cfg_index, i_cfg_data (no read-back)
//
// One character at a time: an accept state, a load state (glyph fetch and clip
// masks), then a 35-step column-major scan, one glyph position per cycle.
// A character outside the font is not scanned; the cursor still advances.
// Clipped positions are still scanned but emit no output word.
// A stalled output word holds the scan in place. Reset is synchronous, active
// low, and sets the panel to 128 x 160 with the cursor at 0,0.

module glyph_5x7_text_rasterizer_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_index,
    input  logic [12:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  gtr_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output gtr_pkg::t_out_word o_out_word
);

    gtr_pkg::t_ctl_cmd   ctl_cmd;
    gtr_pkg::t_dp_status dp_status;

    gtr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (dp_status),
        .o_in_ready (o_in_ready),
        .o_cmd      (ctl_cmd)
    );

    gtr_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_word   (i_in_word),
        .i_cmd       (ctl_cmd),
        .i_out_ready (i_out_ready),
        .o_status    (dp_status),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

// ===== tb/glyph_5x7_text_rasterizer_core_tb.sv =====
`timescale 1ns / 1ps

module glyph_5x7_text_rasterizer_core_tb;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_NEXT = 1'b1;
    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE_CYCLES = 48;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_PCT = 6;

    typedef struct {
        gtr_pkg::t_in_word  word;
        int                 pix_cnt;
        gtr_pkg::t_out_word lead_px;
    } t_char_case;

    logic               i_clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [0:0]         cfg_index = gtr_pkg::REG_PANEL_WIDTH;
    logic [12:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    gtr_pkg::t_in_word  in_word = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    gtr_pkg::t_out_word out_word;

    // font columns 0..4 from the top byte down, rows LSB first
    logic [39:0] font_rom [0:58];

    logic [12:0] panel_w = gtr_pkg::PANEL_W_RESET;
    logic [12:0] panel_h = gtr_pkg::PANEL_H_RESET;
    logic [15:0] cur_col = '0;
    logic [15:0] cur_row = '0;

    gtr_pkg::t_out_word pixel_q [$];
    t_char_case         char_cases [$];
    int                 mismatch_cnt = 0;
    int                 idle_pct = IDLE_PCT;
    bit                 hold_req = 1'b0;
    int                 offer_pix_cnt = -1;
    gtr_pkg::t_out_word offer_lead = '0;
    int                 pred_n;
    gtr_pkg::t_out_word pred_lead;
    gtr_pkg::t_out_word want_px;
    int unsigned        cycle_cnt = 0;

    glyph_5x7_text_rasterizer_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        font_rom[0]  = 40'h00_00_00_00_00; font_rom[1]  = 40'h00_00_5F_00_00;
        font_rom[2]  = 40'h00_07_00_07_00; font_rom[3]  = 40'h14_7F_14_7F_14;
        font_rom[4]  = 40'h24_2A_7F_2A_12; font_rom[5]  = 40'h23_13_08_64_62;
        font_rom[6]  = 40'h36_49_55_22_50; font_rom[7]  = 40'h00_05_03_00_00;
        font_rom[8]  = 40'h00_1C_22_41_00; font_rom[9]  = 40'h00_41_22_1C_00;
        font_rom[10] = 40'h14_08_3E_08_14; font_rom[11] = 40'h08_08_3E_08_08;
        font_rom[12] = 40'h00_50_30_00_00; font_rom[13] = 40'h08_08_08_08_08;
        font_rom[14] = 40'h00_60_60_00_00; font_rom[15] = 40'h20_10_08_04_02;
        font_rom[16] = 40'h3E_51_49_45_3E; font_rom[17] = 40'h00_42_7F_40_00;
        font_rom[18] = 40'h42_61_51_49_46; font_rom[19] = 40'h21_41_45_4B_31;
        font_rom[20] = 40'h18_14_12_7F_10; font_rom[21] = 40'h27_45_45_45_39;
        font_rom[22] = 40'h3C_4A_49_49_30; font_rom[23] = 40'h01_71_09_05_03;
        font_rom[24] = 40'h36_49_49_49_36; font_rom[25] = 40'h06_49_49_29_1E;
        font_rom[26] = 40'h00_36_36_00_00; font_rom[27] = 40'h00_56_36_00_00;
        font_rom[28] = 40'h08_14_22_41_00; font_rom[29] = 40'h14_14_14_14_14;
        font_rom[30] = 40'h00_41_22_14_08; font_rom[31] = 40'h02_01_51_09_06;
        font_rom[32] = 40'h32_49_79_41_3E; font_rom[33] = 40'h7E_11_11_11_7E;
        font_rom[34] = 40'h7F_49_49_49_36; font_rom[35] = 40'h3E_41_41_41_22;
        font_rom[36] = 40'h7F_41_41_22_1C; font_rom[37] = 40'h7F_49_49_49_41;
        font_rom[38] = 40'h7F_09_09_09_01; font_rom[39] = 40'h3E_41_49_49_7A;
        font_rom[40] = 40'h7F_08_08_08_7F; font_rom[41] = 40'h00_41_7F_41_00;
        font_rom[42] = 40'h20_40_41_3F_01; font_rom[43] = 40'h7F_08_14_22_41;
        font_rom[44] = 40'h7F_40_40_40_40; font_rom[45] = 40'h7F_02_0C_02_7F;
        font_rom[46] = 40'h7F_04_08_10_7F; font_rom[47] = 40'h3E_41_41_41_3E;
        font_rom[48] = 40'h7F_09_09_09_06; font_rom[49] = 40'h3E_41_51_21_5E;
        font_rom[50] = 40'h7F_09_19_29_46; font_rom[51] = 40'h46_49_49_49_31;
        font_rom[52] = 40'h01_01_7F_01_01; font_rom[53] = 40'h3F_40_40_40_3F;
        font_rom[54] = 40'h1F_20_40_20_1F; font_rom[55] = 40'h3F_40_38_40_3F;
        font_rom[56] = 40'h63_14_08_14_63; font_rom[57] = 40'h07_08_70_08_07;
        font_rom[58] = 40'h61_51_49_45_43;
    end

    // Expand one character into the pixels it should produce.
    task automatic expand_glyph(input gtr_pkg::t_in_word w, output int n,
                                output gtr_pkg::t_out_word lead);
        logic [12:0]        wl;
        logic [12:0]        hl;
        logic [15:0]        px;
        logic [15:0]        py;
        logic [39:0]        g;
        logic [7:0]         colbits;
        gtr_pkg::t_out_word pend;
        bit                 have_pend;
        int                 c;
        int                 r;
        n = 0;
        lead = '0;
        pend = '0;
        have_pend = 1'b0;
        wl = (panel_w > gtr_pkg::PANEL_MAX) ? gtr_pkg::PANEL_MAX : panel_w;
        hl = (panel_h > gtr_pkg::PANEL_MAX) ? gtr_pkg::PANEL_MAX : panel_h;
        if (w.cmd == CMD_START) begin
            cur_col = w.start_x;
            cur_row = w.start_y;
        end
        if (w.character >= gtr_pkg::GLYPH_FIRST && w.character <= gtr_pkg::GLYPH_LAST) begin
            g = font_rom[w.character - gtr_pkg::GLYPH_FIRST];
            for (c = 0; c < 5; c++) begin
                colbits = g[39 - 8*c -: 8];
                px = cur_col + 16'(c);
                for (r = 0; r < 7; r++) begin
                    py = cur_row + 16'(r);
                    if (px < wl && py < hl) begin
                        if (have_pend)
                            pixel_q.push_back(pend);
                        pend.pixel_x = px[11:0];
                        pend.pixel_y = py[11:0];
                        pend.pixel_color = colbits[r] ? w.fore_color : w.back_color;
                        pend.last_pixel = 1'b0;
                        if (n == 0)
                            lead = pend;
                        have_pend = 1'b1;
                        n++;
                    end
                end
            end
            if (have_pend) begin
                pend.last_pixel = 1'b1;
                pixel_q.push_back(pend);
            end
        end
        cur_col = cur_col + gtr_pkg::CHAR_ADVANCE;
    endtask

    task automatic note_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("mismatch: %s", msg);
    endtask

    always @(posedge i_clk) begin
        if (rst_n && in_valid && in_ready) begin
            expand_glyph(in_word, pred_n, pred_lead);
            if (offer_pix_cnt >= 0 && (pred_n != offer_pix_cnt || (pred_n > 0 &&
                {pred_lead.pixel_x, pred_lead.pixel_y, pred_lead.pixel_color} !==
                {offer_lead.pixel_x, offer_lead.pixel_y, offer_lead.pixel_color})))
                note_mismatch($sformatf(
                    {"char %h: expected %0d pixels from %0d,%0d color %h, ",
                     "got %0d from %0d,%0d color %h"},
                    in_word.character, offer_pix_cnt, offer_lead.pixel_x,
                    offer_lead.pixel_y, offer_lead.pixel_color, pred_n,
                    pred_lead.pixel_x, pred_lead.pixel_y, pred_lead.pixel_color));
        end
        if (rst_n && out_valid && out_ready) begin
            if (pixel_q.size() == 0) begin
                note_mismatch($sformatf("unexpected pixel x=%0d y=%0d color=%h last=%b",
                    out_word.pixel_x, out_word.pixel_y, out_word.pixel_color,
                    out_word.last_pixel));
            end else begin
                want_px = pixel_q.pop_front();
                if (out_word !== want_px)
                    note_mismatch($sformatf(
                        {"pixel expected x=%0d y=%0d color=%h last=%b, ",
                         "got x=%0d y=%0d color=%h last=%b"},
                        want_px.pixel_x, want_px.pixel_y, want_px.pixel_color,
                        want_px.last_pixel, out_word.pixel_x, out_word.pixel_y,
                        out_word.pixel_color, out_word.last_pixel));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver: random stalls, or one long hold-off when asked
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    task automatic offer_char(input gtr_pkg::t_in_word w, input int cnt,
                              input gtr_pkg::t_out_word lead);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        offer_pix_cnt = cnt;
        offer_lead = lead;
        do @(posedge i_clk); while (!in_ready);
    endtask

    // Drop valid, wait for every pixel, then let a clipped scan finish.
    task automatic drain_pixels();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_panel(input logic [12:0] w, input logic [12:0] h);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= gtr_pkg::REG_PANEL_WIDTH;
        cfg_data <= w;
        panel_w = w;
        @(negedge i_clk);
        cfg_index <= gtr_pkg::REG_PANEL_HEIGHT;
        cfg_data <= h;
        panel_h = h;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic gtr_pkg::t_in_word rand_char();
        gtr_pkg::t_in_word w;
        int                wl;
        int                hl;
        wl = (panel_w > gtr_pkg::PANEL_MAX) ? int'(gtr_pkg::PANEL_MAX) : int'(panel_w);
        hl = (panel_h > gtr_pkg::PANEL_MAX) ? int'(gtr_pkg::PANEL_MAX) : int'(panel_h);
        w.cmd = ($urandom_range(99) < 30) ? CMD_START : CMD_NEXT;
        case ($urandom_range(9))
            0: w.start_x = 16'($urandom());
            1: w.start_x = 16'hFFFF - 16'($urandom_range(5));
            default: w.start_x = 16'($urandom_range(wl + 4));
        endcase
        case ($urandom_range(9))
            0: w.start_y = 16'($urandom());
            1: w.start_y = 16'hFFFF - 16'($urandom_range(7));
            default: w.start_y = 16'($urandom_range(hl + 4));
        endcase
        if ($urandom_range(99) < 85)
            w.character = 8'($urandom_range(gtr_pkg::GLYPH_LAST, gtr_pkg::GLYPH_FIRST));
        else
            w.character = 8'($urandom());
        w.fore_color = 16'($urandom());
        w.back_color = 16'($urandom());
        return w;
    endfunction

    task automatic run_phase(input logic [12:0] w, input logic [12:0] h, input int items,
                             input bit quiet, input bit hold);
        set_panel(w, h);
        idle_pct = quiet ? 0 : IDLE_PCT;
        if (hold)
            hold_req = 1'b1;
        repeat (items) offer_char(rand_char(), -1, '0);
        drain_pixels();
        idle_pct = IDLE_PCT;
    endtask

    task automatic add_case(input logic cmd, input logic [15:0] x, input logic [15:0] y,
                            input logic [7:0] ch, input logic [15:0] fg,
                            input logic [15:0] bg, input int cnt, input logic [11:0] lx,
                            input logic [11:0] ly, input logic [15:0] lc);
        t_char_case cc;
        cc.word = '{cmd: cmd, start_x: x, start_y: y, character: ch,
                    fore_color: fg, back_color: bg};
        cc.pix_cnt = cnt;
        cc.lead_px = '{pixel_x: lx, pixel_y: ly, pixel_color: lc, last_pixel: 1'b0};
        char_cases.push_back(cc);
    endtask

    initial begin
        // reset panel 128 x 160, cursor at 0,0; count -1 leaves it to the predictor
        add_case(CMD_NEXT,  16'd0,     16'd0,     8'd65,  16'hFFFF, 16'h0000, 35, 0, 0, 16'h0000);
        add_case(CMD_NEXT,  16'd0,     16'd0,     8'd0,   16'hFFFF, 16'h0000, 0, 0, 0, 16'h0);
        add_case(CMD_NEXT,  16'd0,     16'd0,     8'd31,  16'hFFFF, 16'h0000, 0, 0, 0, 16'h0);
        add_case(CMD_NEXT,  16'd0,     16'd0,     8'd91,  16'hFFFF, 16'h0000, 0, 0, 0, 16'h0);
        add_case(CMD_NEXT,  16'd0,     16'd0,     8'd255, 16'hFFFF, 16'h0000, 0, 0, 0, 16'h0);
        add_case(CMD_NEXT,  16'd0,     16'd0,     8'd32,  16'h1234, 16'hABCD, 35, 30, 0, 16'hABCD);
        add_case(CMD_START, 16'd0,     16'd0,     8'd90,  16'hF800, 16'h001F, 35, 0, 0, 16'hF800);
        add_case(CMD_START, 16'hFFFF,  16'd0,     8'd90,  16'h07E0, 16'h0000, 28, 0, 0, 16'h07E0);
        add_case(CMD_START, 16'd0,     16'hFFFE,  8'd90,  16'hFFFF, 16'h0001, 25, 0, 0, 16'h0001);
        add_case(CMD_START, 16'd126,   16'd158,   8'd90,  16'h5555, 16'hAAAA, 4, 126, 158, 16'h5555);
        add_case(CMD_START, 16'd128,   16'd0,     8'd65,  16'hFFFF, 16'h0000, 0, 0, 0, 16'h0);
        add_case(CMD_START, 16'd0,     16'd160,   8'd65,  16'hFFFF, 16'h0000, 0, 0, 0, 16'h0);
        add_case(CMD_START, 16'hFFFF,  16'hFFFF,  8'd66,  16'hFFFF, 16'h0000, 24, 0, 0, 16'h0000);
        add_case(CMD_NEXT,  16'hFFFF,  16'hFFFF,  8'd48,  16'h8000, 16'h7FFF, -1, 0, 0, 16'h0);
        add_case(CMD_START, 16'd100,   16'd10,    8'd72,  16'h001F, 16'hFFE0, -1, 0, 0, 16'h0);
        add_case(CMD_NEXT,  16'h8000,  16'h8000,  8'd69,  16'h001F, 16'hFFE0, -1, 0, 0, 16'h0);
        add_case(CMD_NEXT,  16'd0,     16'd0,     8'd76,  16'h001F, 16'hFFE0, -1, 0, 0, 16'h0);
        add_case(CMD_NEXT,  16'd0,     16'd0,     8'd76,  16'h001F, 16'hFFE0, -1, 0, 0, 16'h0);
        add_case(CMD_NEXT,  16'd0,     16'd0,     8'd79,  16'h001F, 16'hFFE0, -1, 0, 0, 16'h0);
        add_case(CMD_NEXT,  16'd0,     16'd0,     8'd127, 16'h001F, 16'hFFE0, 0, 0, 0, 16'h0);
        add_case(CMD_START, 16'd10,    16'd153,   8'd33,  16'h0000, 16'hFFFF, 35, 10, 153, 16'hFFFF);
        add_case(CMD_NEXT,  16'd0,     16'd0,     8'd64,  16'hC3C3, 16'h3C3C, -1, 0, 0, 16'h0);

        repeat (12) @(negedge i_clk);
        rst_n <= 1'b1;

        foreach (char_cases[k])
            offer_char(char_cases[k].word, char_cases[k].pix_cnt, char_cases[k].lead_px);
        drain_pixels();

        run_phase(13'd128,  13'd160,  30, 1'b0, 1'b1);
        run_phase(13'd4096, 13'd4096, 35, 1'b1, 1'b0);
        run_phase(13'd1,    13'd1,    15, 1'b0, 1'b0);
        run_phase(13'd0,    13'd40,   10, 1'b0, 1'b0);
        run_phase(13'd8191, 13'd8191, 30, 1'b0, 1'b0);
        run_phase(13'd24,   13'd16,   30, 1'b0, 1'b0);
        run_phase(13'd4095, 13'd3,    25, 1'b0, 1'b0);
        run_phase(13'd300,  13'd200,  30, 1'b0, 1'b0);

        if (pixel_q.size() != 0)
            note_mismatch($sformatf("%0d pixels never arrived", pixel_q.size()));
        if (mismatch_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
